/* design/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dhit_pkg.sv */
package dhit_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CSR_W      = 4;
   localparam int OUT_CNT_W  = 11;
   localparam int MIN_LOG2   = 3;

   // request codes
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_MISS   = 2'd1;
   localparam logic [1:0] STATUS_INSERT = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   // slot tags
   localparam logic [1:0] TAG_EMPTY = 2'd0;
   localparam logic [1:0] TAG_LIVE  = 2'd1;
   localparam logic [1:0] TAG_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] value_out;
      logic [OUT_CNT_W-1:0]  live_entries;
      logic [OUT_CNT_W-1:0]  probe_steps;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]            tag;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

endpackage

/* design/double_hash_identity_table_core.sv */
// channel  | ports                       | handshake
// ---------+-----------------------------+-------------------------------------
// request  | start, busy, req_item       | taken at edge with start & !busy
// result   | rsp_valid, rsp_item         | one-cycle strobe, always taken
// config   | csr_we, csr_wdata           | written at edge with csr_we high
//
// Lookup/store/remove: the probe sequence is walked one slot at a time, set by
//   the single read port of the slot memory, whose read data is registered;
//   the result is registered from the last probe.
// Clear: one slot emptied per cycle over the full memory.
// Reset runs the same sweep (busy high, no result).
// A new item may be taken in the cycle its predecessor's result is shown.
// The receiver cannot stall; results are never held.
`include "assert_macros.svh"

module double_hash_identity_table_core #(
   parameter int MAX_SIZE_LOG2 = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dhit_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   output dhit_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_we,
   input  logic [dhit_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int AW    = MAX_SIZE_LOG2;       // slot address width
   localparam int CNT_W = MAX_SIZE_LOG2 + 1;   // counts up to slot count
   localparam int FW    = CNT_W + 3;           // fill-bound product width
   localparam int SLOTS = 1 << MAX_SIZE_LOG2;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   // slot memory: tag, key and value of each slot in one word
   dhit_pkg::entry_type mem [SLOTS];
   dhit_pkg::entry_type mem_rdata_ff;
   dhit_pkg::entry_type mem_wdata;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic                mem_we, mem_re;

   logic [1:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_idx_ff, clr_idx_in;
   logic                        clr_rsp_ff, clr_rsp_in;
   dhit_pkg::req_item_type      req_ff, req_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [AW-1:0]               stride_ff, stride_in;
   logic [CNT_W-1:0]            steps_ff, steps_in;
   logic                        tomb_seen_ff, tomb_seen_in;
   logic [AW-1:0]               tomb_pos_ff, tomb_pos_in;
   logic [CNT_W-1:0]            live_ff, live_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [dhit_pkg::CSR_W-1:0]  csr_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   dhit_pkg::rsp_item_type      rsp_ff, rsp_in;

   // table geometry from the size register, clamped to the legal range
   logic [4:0]       csr_ext, eff_log2;
   logic [CNT_W-1:0] size;
   logic [AW-1:0]    mask;
   logic             fill_ok;

   assign csr_ext  = {1'b0, csr_ff};
   assign eff_log2 = (csr_ext < 5'(dhit_pkg::MIN_LOG2)) ? 5'(dhit_pkg::MIN_LOG2) :
                     (csr_ext > 5'(MAX_SIZE_LOG2))      ? 5'(MAX_SIZE_LOG2) : csr_ext;
   assign size     = CNT_W'(1) << eff_log2;
   assign mask     = AW'(size - CNT_W'(1));
   // insert into an empty slot allowed while used * 7 < size * 5
   assign fill_ok  = ((FW'(used_ff) << 3) - FW'(used_ff)) < ((FW'(size) << 2) + FW'(size));

   // current probe classification
   logic             is_empty, is_match, is_tomb, last_probe, ends;
   logic             tomb_any;
   logic [AW-1:0]    tomb_at;
   logic [CNT_W-1:0] steps_out;

   assign is_empty   = mem_rdata_ff.tag == dhit_pkg::TAG_EMPTY;
   assign is_match   = (mem_rdata_ff.tag == dhit_pkg::TAG_LIVE) &&
                       (mem_rdata_ff.key == req_ff.key);
   assign is_tomb    = !is_empty && (mem_rdata_ff.tag != dhit_pkg::TAG_LIVE);
   assign last_probe = steps_ff == {1'b0, mask};
   assign ends       = is_empty || is_match;
   assign tomb_any   = tomb_seen_ff || is_tomb;
   assign tomb_at    = tomb_seen_ff ? tomb_pos_ff : pos_ff;
   assign steps_out  = ends ? steps_ff : steps_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      clr_rsp_in   = clr_rsp_ff;
      req_in       = req_ff;
      pos_in       = pos_ff;
      stride_in    = stride_ff;
      steps_in     = steps_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_pos_in  = tomb_pos_ff;
      live_in      = live_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = '{tag: dhit_pkg::TAG_LIVE, key: req_ff.key, value: req_ff.value};
      mem_re       = 1'b0;
      mem_raddr    = pos_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // empty one slot per cycle over the full memory
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '{tag: dhit_pkg::TAG_EMPTY, key: '0, value: '0};
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.req_type == dhit_pkg::REQ_CLEAR) begin
                  state_in   = ST_CLEAR;
                  clr_idx_in = '0;
                  clr_rsp_in = 1'b1;
                  live_in    = '0;
                  used_in    = '0;
               end else begin
                  pos_in       = AW'(req_item.key >> 2) & mask;
                  stride_in    = (AW'(req_item.key >> 3) & mask) | AW'(1);
                  steps_in     = '0;
                  tomb_seen_in = 1'b0;
                  mem_re       = 1'b1;
                  mem_raddr    = pos_in;
                  state_in     = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (!ends && !last_probe) begin
               // keep walking the probe sequence
               steps_in = steps_ff + CNT_W'(1);
               if (is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_pos_in  = pos_ff;
               end
               pos_in    = (pos_ff + stride_ff) & mask;
               mem_re    = 1'b1;
               mem_raddr = pos_in;
            end else begin
               state_in         = ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.status    = dhit_pkg::STATUS_MISS;
               rsp_in.value_out = '0;
               unique case (req_ff.req_type)
                  dhit_pkg::REQ_LOOKUP: begin
                     if (is_match) begin
                        rsp_in.status    = dhit_pkg::STATUS_OK;
                        rsp_in.value_out = mem_rdata_ff.value;
                     end
                  end
                  dhit_pkg::REQ_REMOVE: begin
                     if (is_match) begin
                        mem_we        = 1'b1;
                        mem_wdata     = '{tag: dhit_pkg::TAG_TOMB, key: mem_rdata_ff.key,
                                          value: '0};
                        rsp_in.status = dhit_pkg::STATUS_OK;
                        if (live_ff != '0) begin
                           live_in = live_ff - CNT_W'(1);
                        end
                     end
                  end
                  dhit_pkg::REQ_STORE: begin
                     priority if (is_match) begin
                        mem_we        = 1'b1;
                        rsp_in.status = dhit_pkg::STATUS_OK;
                     end else if (tomb_any) begin
                        // reuse the first tombstone passed
                        mem_we        = 1'b1;
                        mem_waddr     = tomb_at;
                        live_in       = live_ff + CNT_W'(1);
                        rsp_in.status = dhit_pkg::STATUS_INSERT;
                     end else if (is_empty && fill_ok) begin
                        mem_we        = 1'b1;
                        live_in       = live_ff + CNT_W'(1);
                        used_in       = used_ff + CNT_W'(1);
                        rsp_in.status = dhit_pkg::STATUS_INSERT;
                     end else begin
                        rsp_in.status = dhit_pkg::STATUS_FULL;
                     end
                  end
                  dhit_pkg::REQ_CLEAR: begin
                     rsp_in.status = dhit_pkg::STATUS_OK;
                  end
               endcase
               rsp_in.live_entries = dhit_pkg::OUT_CNT_W'(live_in);
               rsp_in.probe_steps  = dhit_pkg::OUT_CNT_W'(steps_out);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         live_ff      <= '0;
         used_ff      <= '0;
         csr_ff       <= dhit_pkg::CSR_W'(dhit_pkg::MIN_LOG2);
         rsp_valid_ff <= 1'b0;
         tomb_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         live_ff      <= live_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         tomb_seen_ff <= tomb_seen_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      stride_ff   <= stride_in;
      steps_ff    <= steps_in;
      tomb_pos_ff <= tomb_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")
   `ASSERT_IMPL(a_live_le_used, clock, reset, 1'b1, live_ff <= used_ff, "live count above used count")

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int MAX_LOG2     = 10;
   localparam int TABLE_DEPTH  = 1 << MAX_LOG2;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int DIRECTED_N   = 26;

   localparam logic [31:0] KEY_ALL1  = 32'hFFFF_FFFF;
   localparam logic [31:0] KEY_BASE  = 32'hA500_0000;   // bits 2..5 pick the home slot
   localparam logic [31:0] KEY_SWEEP = 32'h0000_1000;   // home slot 0, stride 1 at 8 slots
   localparam logic [31:0] KEY_LATE  = 32'h0000_2000;   // home slot 0 as well

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one directed row: either a register write or an item, with an optional
   // hand-typed result (otherwise the predictor decides)
   typedef struct packed {
      row_kind_type           kind;
      logic [3:0]             size_log2;
      dhit_pkg::req_item_type req;
      logic                   typed;
      dhit_pkg::rsp_item_type rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   dhit_pkg::req_item_type req_item;
   logic                   rsp_valid;
   dhit_pkg::rsp_item_type rsp_item;
   logic                   csr_we;
   logic [3:0]             csr_wdata;

   // predictor state
   logic [1:0]   slot_tag_q  [TABLE_DEPTH];
   logic [31:0]  slot_key_q  [TABLE_DEPTH];
   logic [31:0]  slot_val_q  [TABLE_DEPTH];
   int unsigned  live_cnt;
   int unsigned  used_cnt;
   logic [3:0]   size_log2_q;

   dhit_pkg::rsp_item_type pending_rsps[$];
   int                     fail_count;
   int unsigned            cycle_count;

   // directed table; rows without a typed result are checked by the predictor
   stim_row_type directed_rows [DIRECTED_N] = '{
      // empty table after reset
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_LOOKUP, KEY_ALL1, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_MISS, 32'd0, 11'd0, 11'd0}},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_ALL1, 32'hFFFF_FFFF}, 1'b1,
        '{dhit_pkg::STATUS_INSERT, 32'd0, 11'd1, 11'd0}},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_LOOKUP, KEY_ALL1, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'hFFFF_FFFF, 11'd1, 11'd0}},
      // store of zero updates, does not delete
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_ALL1, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'd0, 11'd1, 11'd0}},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_LOOKUP, KEY_ALL1, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'd0, 11'd1, 11'd0}},
      // key zero is an ordinary key
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, 32'd0, 32'h1234_5678}, 1'b1,
        '{dhit_pkg::STATUS_INSERT, 32'd0, 11'd2, 11'd0}},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_LOOKUP, 32'd0, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'h1234_5678, 11'd2, 11'd0}},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_REMOVE, 32'd0, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'd0, 11'd1, 11'd0}},
      // second remove walks past the tombstone; store then reuses it
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_REMOVE, 32'd0, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, 32'd0, 32'd5}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_CLEAR, 32'd0, 32'd0}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'd0, 11'd0, 11'd0}},
      // fill home slots 0..7 at 16 slots, then shrink to 8: no empty slot left
      '{ROW_CSR, 4'd4, '0, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd0 << 2), 32'd10}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd1 << 2), 32'd11}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd2 << 2), 32'd12}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd3 << 2), 32'd13}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd4 << 2), 32'd14}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd5 << 2), 32'd15}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd6 << 2), 32'd16}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_BASE | (32'd7 << 2), 32'd17}, 1'b0, '0},
      '{ROW_CSR, 4'd3, '0, 1'b0, '0},
      // full sweep miss, tombstone reuse with no empty slot, then refused
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_LOOKUP, KEY_SWEEP, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_REMOVE, KEY_BASE | (32'd3 << 2), 32'd0}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_SWEEP, 32'h0F0F_0F0F}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_STORE, KEY_LATE, 32'd1}, 1'b0, '0},
      '{ROW_ITEM, 4'd0, '{dhit_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
        '{dhit_pkg::STATUS_OK, 32'd0, 11'd0, 11'd0}}
   };

   double_hash_identity_table_core #(
      .MAX_SIZE_LOG2(MAX_LOG2)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor: one request against the shadow table. Returns the result
   // and commits the state change, in acceptance order.
   function automatic dhit_pkg::rsp_item_type probe_table(dhit_pkg::req_item_type req);
      int unsigned            lg;
      int unsigned            slots;
      int unsigned            mask;
      int unsigned            pos;
      int unsigned            stride;
      int unsigned            steps;
      int unsigned            tomb_pos;
      bit                     found;
      bit                     hit_empty;
      bit                     tomb_seen;
      dhit_pkg::rsp_item_type rsp;

      lg = size_log2_q;
      if (lg < dhit_pkg::MIN_LOG2) lg = dhit_pkg::MIN_LOG2;
      if (lg > MAX_LOG2) lg = MAX_LOG2;
      slots     = 1 << lg;
      mask      = slots - 1;
      rsp       = '0;
      steps     = 0;
      tomb_pos  = 0;
      found     = 1'b0;
      hit_empty = 1'b0;
      tomb_seen = 1'b0;

      if (req.req_type == dhit_pkg::REQ_CLEAR) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_tag_q[i] = dhit_pkg::TAG_EMPTY;
         live_cnt   = 0;
         used_cnt   = 0;
         rsp.status = dhit_pkg::STATUS_OK;
         return rsp;
      end

      pos    = (req.key >> 2) & mask;
      stride = ((req.key >> 3) & mask) | 1;
      // walk until a match or an empty slot, at most once round the table
      for (int n = 0; n < slots; n++) begin
         if (slot_tag_q[pos] == dhit_pkg::TAG_EMPTY) begin
            hit_empty = 1'b1;
            break;
         end
         if (slot_tag_q[pos] == dhit_pkg::TAG_LIVE && slot_key_q[pos] == req.key) begin
            found = 1'b1;
            break;
         end
         if (slot_tag_q[pos] != dhit_pkg::TAG_LIVE && !tomb_seen) begin
            tomb_seen = 1'b1;
            tomb_pos  = pos;
         end
         steps++;
         pos = (pos + stride) & mask;
      end

      case (req.req_type)
         dhit_pkg::REQ_LOOKUP: begin
            if (found) begin
               rsp.status    = dhit_pkg::STATUS_OK;
               rsp.value_out = slot_val_q[pos];
            end else begin
               rsp.status = dhit_pkg::STATUS_MISS;
            end
         end
         dhit_pkg::REQ_REMOVE: begin
            if (found) begin
               slot_tag_q[pos] = dhit_pkg::TAG_TOMB;
               slot_val_q[pos] = '0;
               if (live_cnt > 0) live_cnt--;
               rsp.status = dhit_pkg::STATUS_OK;
            end else begin
               rsp.status = dhit_pkg::STATUS_MISS;
            end
         end
         default: begin
            if (found) begin
               slot_val_q[pos] = req.value;
               rsp.status      = dhit_pkg::STATUS_OK;
            end else if (tomb_seen) begin
               slot_tag_q[tomb_pos] = dhit_pkg::TAG_LIVE;
               slot_key_q[tomb_pos] = req.key;
               slot_val_q[tomb_pos] = req.value;
               live_cnt++;
               rsp.status = dhit_pkg::STATUS_INSERT;
            end else if (hit_empty && used_cnt * 7 < slots * 5) begin
               // fill bound: used * 1.4 must stay below the slot count
               slot_tag_q[pos] = dhit_pkg::TAG_LIVE;
               slot_key_q[pos] = req.key;
               slot_val_q[pos] = req.value;
               used_cnt++;
               live_cnt++;
               rsp.status = dhit_pkg::STATUS_INSERT;
            end else begin
               rsp.status = dhit_pkg::STATUS_FULL;
            end
         end
      endcase

      rsp.live_entries = live_cnt[dhit_pkg::OUT_CNT_W-1:0];
      rsp.probe_steps  = steps[dhit_pkg::OUT_CNT_W-1:0];
      return rsp;
   endfunction

   // Entered and left just after a rising edge. Holds start low for the gap
   // given, then offers the item until taken; start stays high on exit so
   // a zero-gap successor follows without a bubble.
   task automatic send_item(dhit_pkg::req_item_type req, int unsigned gap, bit typed,
                            dhit_pkg::rsp_item_type typed_rsp);
      dhit_pkg::rsp_item_type predicted;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= req;
      do @(posedge clock); while (busy);
      predicted = probe_table(req);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   // drop start and wait until every outstanding result is back
   task automatic drain_table;
      start <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0 || busy);
   endtask

   task automatic write_size(logic [3:0] size_log2);
      drain_table();
      csr_we    <= 1'b1;
      csr_wdata <= size_log2;
      @(posedge clock);
      size_log2_q = size_log2;
      csr_we    <= 1'b0;
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // result checker: a strobe is taken at the edge that ends its cycle
   always @(posedge clock) begin
      dhit_pkg::rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual %0h",
                     $time, rsp_item);
         end else begin
            want = pending_rsps.pop_front();
            report_field("status", 32'(want.status), 32'(rsp_item.status));
            report_field("value_out", want.value_out, rsp_item.value_out);
            report_field("live_entries", 32'(want.live_entries),
                         32'(rsp_item.live_entries));
            report_field("probe_steps", 32'(want.probe_steps),
                         32'(rsp_item.probe_steps));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** double_hash_identity_table_core: FAILED **");
         $finish;
      end
   end

   initial begin
      dhit_pkg::req_item_type req;
      logic [31:0]            key_pool[$];
      int unsigned            random_sent;
      int unsigned            phase;
      int unsigned            phase_len;
      int unsigned            pick;
      logic [3:0]             size_sel;
      bit                     no_gaps;

      reset       <= 1'b1;
      start       <= 1'b0;
      req_item    <= '0;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      fail_count   = 0;
      live_cnt     = 0;
      used_cnt     = 0;
      size_log2_q  = 4'd3;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_tag_q[i] = dhit_pkg::TAG_EMPTY;
         slot_key_q[i] = '0;
         slot_val_q[i] = '0;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_size(directed_rows[r].size_log2);
         else
            send_item(directed_rows[r].req, $urandom_range(0, 4),
                      directed_rows[r].typed, directed_rows[r].rsp);
      end

      // random part: phases of one size setting each, keys mostly drawn from a
      // small per-phase pool so stores, hits, removals and refusals mix
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase)
            0: size_sel = 4'd10;      // largest table
            1: size_sel = 4'd15;      // above range, clamps to largest
            2: size_sel = 4'd0;       // below range, clamps to smallest
            default: begin
               pick = $urandom_range(0, 9);
               if (pick <= 4)      size_sel = 4'($urandom_range(3, 5));
               else if (pick <= 6) size_sel = 4'($urandom_range(6, 8));
               else if (pick == 7) size_sel = 4'($urandom_range(9, 10));
               else                size_sel = 4'($urandom_range(0, 15));
            end
         endcase
         write_size(size_sel);

         key_pool.delete();
         repeat ($urandom_range(4, 40)) key_pool.push_back($urandom);
         no_gaps   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 150);

         if ($urandom_range(0, 1)) begin
            req = '{dhit_pkg::REQ_CLEAR, $urandom, $urandom};
            send_item(req, no_gaps ? 0 : $urandom_range(0, 4), 1'b0, '0);
            random_sent++;
         end

         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       req.req_type = dhit_pkg::REQ_CLEAR;
            else if (pick < 44) req.req_type = dhit_pkg::REQ_STORE;
            else if (pick < 72) req.req_type = dhit_pkg::REQ_LOOKUP;
            else                req.req_type = dhit_pkg::REQ_REMOVE;
            if ($urandom_range(0, 9) == 0) req.key = $urandom;
            else req.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            req.value = $urandom;
            send_item(req, no_gaps ? 0 : $urandom_range(0, 4), 1'b0, '0);
            random_sent++;
            // occasional full stop of the sender until the table is idle
            if ($urandom_range(0, 99) == 0) drain_table();
         end
         phase++;
      end

      drain_table();
      repeat (16) @(posedge clock);

      if (fail_count == 0 && pending_rsps.size() == 0) begin
         $display("** double_hash_identity_table_core: PASSED **");
      end else begin
         $display("** double_hash_identity_table_core: FAILED **");
      end
      $finish;
   end

endmodule

/* double_hash_identity_table_core.f */
+incdir+design
design/dhit_pkg.sv
design/double_hash_identity_table_core.sv
sim/tb.sv
